FILE: hdl/mac_learning_table_core_macros.svh
// ----------------------------------------------------------------------------
// mac_learning_table_core assertion macros
// Concurrent assertion wrappers clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MAC_LEARNING_TABLE_CORE_MACROS_SVH
`define MAC_LEARNING_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MLT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MLT_ASSERT(lbl, ante, cons, msg)
`define MLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants of the address learning table.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

  localparam int NUM_BUCKETS_DEF = 256;
  localparam int WAYS_DEF        = 4;
  localparam int NUM_PORTS_DEF   = 16;

  localparam int ADDR_W  = 48;
  localparam int PORT_W  = 4;
  localparam int STAMP_W = 32;
  localparam int AGE_W   = 12;
  localparam int COUNT_W = 11;
  localparam int CNT_W   = 5;   // ways aged in one bucket, WAYS <= 16

  localparam logic [AGE_W-1:0]   AGE_LIMIT_RST = 12'd30;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 11'h7FF;

  typedef enum logic [1:0] {
    OP_LEARN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_TICK   = 2'd2,
    OP_SWEEP  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [PORT_W-1:0]  port;
    logic [ADDR_W-1:0]  addr;
    logic               valid;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
    logic              dropped;
    logic [CNT_W-1:0]  aged_cnt;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/mlt_ram.sv
// ----------------------------------------------------------------------------
// mlt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mlt_hash.sv
// ----------------------------------------------------------------------------
// mlt_hash
// Bucket index: XOR fold of the six address bytes, reduced mod NUM_BUCKETS.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_hash #(
  parameter int NUM_BUCKETS = mlt_pkg::NUM_BUCKETS_DEF
) (
  input  wire logic [mlt_pkg::ADDR_W-1:0]     mac,
  output logic      [$clog2(NUM_BUCKETS)-1:0] bucket
);

  localparam int BW = $clog2(NUM_BUCKETS);

  logic [7:0]    fold;
  logic [BW-1:0] mod_tbl [256];

  assign fold = mac[7:0] ^ mac[15:8] ^ mac[23:16] ^ mac[31:24] ^ mac[39:32] ^ mac[47:40];

  // reduction table built at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_tbl
    assign mod_tbl[g] = BW'(g % NUM_BUCKETS);
  end

  assign bucket = mod_tbl[fold];

endmodule

`default_nettype wire

FILE: hdl/mlt_bucket.sv
// ----------------------------------------------------------------------------
// mlt_bucket
// Read-modify-write logic for one bucket row: match, learn, refresh, age.
// ----------------------------------------------------------------------------
`default_nettype none

module mlt_bucket #(
  parameter int WAYS      = mlt_pkg::WAYS_DEF,
  parameter int NUM_PORTS = mlt_pkg::NUM_PORTS_DEF
) (
  input  wire mlt_pkg::entry_t [WAYS-1:0]      row,
  input  wire mlt_pkg::opcode_t                op,
  input  wire logic [mlt_pkg::ADDR_W-1:0]      mac,
  input  wire logic [mlt_pkg::PORT_W-1:0]      port_in,
  input  wire logic [mlt_pkg::STAMP_W-1:0]     now,
  input  wire logic [mlt_pkg::AGE_W-1:0]       age_limit,
  output mlt_pkg::entry_t [WAYS-1:0]           row_next,
  output mlt_pkg::result_t                     res
);

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic            match_any;
  logic            free_any;
  logic [IW-1:0]   match_idx;
  logic [IW-1:0]   free_idx;
  logic [WAYS-1:0] aged;
  logic            port_ok;

  assign port_ok = 32'(port_in) < NUM_PORTS;

  always_comb begin
    match_any = 1'b0;
    free_any  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    aged      = '0;
    // descending scan so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row[w].valid && (row[w].addr == mac)) begin
        match_any = 1'b1;
        match_idx = IW'(w);
      end
      if (!row[w].valid) begin
        free_any = 1'b1;
        free_idx = IW'(w);
      end
      aged[w] = row[w].valid &&
                ((now - row[w].stamp) >= {{(mlt_pkg::STAMP_W - mlt_pkg::AGE_W){1'b0}}, age_limit});
    end
  end

  always_comb begin
    row_next = row;
    res      = '0;
    unique case (op)
      mlt_pkg::OP_LEARN: begin
        if (port_ok) begin
          if (match_any) begin
            row_next[match_idx].stamp = now;
            res.hit = 1'b1;
          end else if (free_any) begin
            row_next[free_idx].valid = 1'b1;
            row_next[free_idx].addr  = mac;
            row_next[free_idx].port  = port_in;
            row_next[free_idx].stamp = now;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      mlt_pkg::OP_LOOKUP: begin
        if (match_any) begin
          row_next[match_idx].stamp = now;
          res.hit  = 1'b1;
          res.port = row[match_idx].port;
        end
      end
      mlt_pkg::OP_SWEEP: begin
        for (int w = 0; w < WAYS; w++) begin
          if (aged[w]) begin
            row_next[w].valid = 1'b0;
          end
        end
        res.aged_cnt = mlt_pkg::CNT_W'($countones(aged));
      end
      default: begin
        // tick leaves the row alone
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/mac_learning_table_core.sv
// ----------------------------------------------------------------------------
// mac_learning_table_core
// Hashed address-to-port learning table with aging, bucket rows in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: mac_addr, port_in; tuser: opcode
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: hit, port_out, learn_dropped, removed_count
//  cfg      in   cfg_valid/cfg_ready          cfg_data: age_limit
//
//  Learn, lookup and tick do one RAM read of the bucket row, then a compare
//  in S_ACCESS; learn and lookup also write the row back. Sweep goes one
//  row per cycle through the RAM read and write ports, then reports in S_FINISH.
//  After reset a clearing pass writes every row, with no item accepted. A result
//  waiting on m_axis holds the next item in S_ACCESS; a new item is taken
//  while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_learning_table_core #(
  parameter int NUM_BUCKETS = mlt_pkg::NUM_BUCKETS_DEF,
  parameter int WAYS        = mlt_pkg::WAYS_DEF,
  parameter int NUM_PORTS   = mlt_pkg::NUM_PORTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // mac_addr[47:0], port_in[51:48], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // hit[0], port_out[4:1], learn_dropped[5],
                                           // removed_count[16:6], zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data        // age_limit[11:0]
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int ROW_W = WAYS * mlt_pkg::ENTRY_W;
  localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t                       state, state_next;
  logic [BW-1:0]                row_cnt, row_cnt_next;
  logic [mlt_pkg::STAMP_W-1:0]  now_seconds, now_seconds_next;
  logic [mlt_pkg::AGE_W-1:0]    age_limit;
  logic [mlt_pkg::COUNT_W-1:0]  removed, removed_next;
  logic                         out_valid;

  mlt_pkg::opcode_t             op_q;
  logic [mlt_pkg::ADDR_W-1:0]   mac_q;
  logic [mlt_pkg::PORT_W-1:0]   port_q;
  logic [BW-1:0]                bucket_q;

  logic                         out_hit, out_drop;
  logic [mlt_pkg::PORT_W-1:0]   out_port;
  logic [mlt_pkg::COUNT_W-1:0]  out_removed;

  logic                         accept, out_free, out_load;
  mlt_pkg::opcode_t             in_op;
  logic [BW-1:0]                in_bucket;
  logic                         rd_en, wr_en;
  logic [BW-1:0]                rd_addr, wr_addr;
  mlt_pkg::entry_t [WAYS-1:0]   rd_row, new_row, wr_row;
  logic [ROW_W-1:0]             rd_vec;
  mlt_pkg::result_t             res;
  logic [mlt_pkg::COUNT_W:0]    sum;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_op         = mlt_pkg::opcode_t'(s_axis_tuser);
  assign out_free      = !out_valid || m_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_removed, out_drop, out_port, out_hit};

  mlt_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
    .mac    (s_axis_tdata[47:0]),
    .bucket (in_bucket)
  );

  mlt_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_vec)
  );

  assign rd_row = rd_vec;

  mlt_bucket #(.WAYS(WAYS), .NUM_PORTS(NUM_PORTS)) u_bucket (
    .row       (rd_row),
    .op        (op_q),
    .mac       (mac_q),
    .port_in   (port_q),
    .now       (now_seconds),
    .age_limit (age_limit),
    .row_next  (new_row),
    .res       (res)
  );

  // saturating sweep count
  assign sum = {1'b0, removed} + (mlt_pkg::COUNT_W + 1)'(res.aged_cnt);

  // RAM ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = row_cnt;
    wr_row  = new_row;
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = (in_op == mlt_pkg::OP_SWEEP) ? '0 : in_bucket;
    end else if (state == S_SWEEP && row_cnt != LAST_ROW) begin
      rd_en   = 1'b1;
      rd_addr = BW'(row_cnt + 1'b1);
    end
    if (state == S_CLEAR) begin
      wr_en  = 1'b1;
      wr_row = '0;
    end else if (state == S_SWEEP) begin
      wr_en = 1'b1;
    end else if (state == S_ACCESS && out_free &&
                 (op_q == mlt_pkg::OP_LEARN || op_q == mlt_pkg::OP_LOOKUP)) begin
      wr_en   = 1'b1;
      wr_addr = bucket_q;
    end
  end

  always_comb begin
    state_next       = state;
    row_cnt_next     = row_cnt;
    now_seconds_next = now_seconds;
    removed_next     = removed;
    out_load         = 1'b0;
    unique case (state)
      S_CLEAR: begin
        row_cnt_next = BW'(row_cnt + 1'b1);
        if (row_cnt == LAST_ROW) begin
          row_cnt_next = '0;
          state_next   = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          removed_next = '0;
          row_cnt_next = '0;
          state_next   = (in_op == mlt_pkg::OP_SWEEP) ? S_SWEEP : S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (op_q == mlt_pkg::OP_TICK) begin
            now_seconds_next = now_seconds + 1'b1;
          end
        end
      end
      S_SWEEP: begin
        removed_next = sum[mlt_pkg::COUNT_W] ? mlt_pkg::COUNT_MAX : sum[mlt_pkg::COUNT_W-1:0];
        row_cnt_next = BW'(row_cnt + 1'b1);
        if (row_cnt == LAST_ROW) begin
          row_cnt_next = '0;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      row_cnt     <= '0;
      now_seconds <= '0;
      removed     <= '0;
      age_limit   <= mlt_pkg::AGE_LIMIT_RST;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      row_cnt     <= row_cnt_next;
      now_seconds <= now_seconds_next;
      removed     <= removed_next;
      if (cfg_valid && cfg_ready) begin
        age_limit <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= in_op;
      mac_q    <= s_axis_tdata[47:0];
      port_q   <= s_axis_tdata[51:48];
      bucket_q <= in_bucket;
    end
    if (out_load) begin
      if (state == S_FINISH) begin
        out_hit     <= 1'b0;
        out_port    <= '0;
        out_drop    <= 1'b0;
        out_removed <= removed;
      end else begin
        out_hit     <= res.hit;
        out_port    <= res.port;
        out_drop    <= res.dropped;
        out_removed <= '0;
      end
    end
  end

`include "mac_learning_table_core_macros.svh"

  `MLT_ASSERT(a_no_rw_collide, wr_en && rd_en, wr_addr != rd_addr, "row read and written together")
  `MLT_ASSERT_NEXT(a_sweep_start, accept && in_op == mlt_pkg::OP_SWEEP, state == S_SWEEP, "sweep not started")
  `MLT_ASSERT_NEXT(a_sweep_end, state == S_SWEEP && row_cnt == LAST_ROW, state == S_FINISH, "sweep overran")
  `MLT_ASSERT(a_hit_xor_drop, m_axis_tvalid, !(out_hit && out_drop), "hit and drop both set")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the address learning table: a shadow table predicts
// every reply, replies are compared field by field in order, and traffic is
// steered into a few hot buckets so that full buckets, refreshes and aging
// sweeps under several age limits are all exercised.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int NUM_BUCKETS = mlt_pkg::NUM_BUCKETS_DEF;
  localparam int WAYS        = mlt_pkg::WAYS_DEF;
  localparam int NUM_PORTS   = mlt_pkg::NUM_PORTS_DEF;
  localparam int TABLE_SIZE  = NUM_BUCKETS * WAYS;
  localparam int MAX_REPORTS = 10;
  localparam int ADDR_W      = mlt_pkg::ADDR_W;
  localparam int PORT_W      = mlt_pkg::PORT_W;
  localparam int STAMP_W     = mlt_pkg::STAMP_W;
  localparam int AGE_W       = mlt_pkg::AGE_W;
  localparam int COUNT_W     = mlt_pkg::COUNT_W;

  typedef struct packed {
    logic               hit;
    logic [PORT_W-1:0]  port;
    logic               dropped;
    logic [COUNT_W-1:0] removed;
  } reply_t;

  // Shadow copy of the table; predicts the reply of each accepted item.
  class learning_table_shadow;
    bit                 occupied[TABLE_SIZE];
    logic [ADDR_W-1:0]  station[TABLE_SIZE];
    logic [PORT_W-1:0]  bound_port[TABLE_SIZE];
    logic [STAMP_W-1:0] last_seen[TABLE_SIZE];
    logic [STAMP_W-1:0] seconds;
    logic [AGE_W-1:0]   age_limit;
    reply_t             pending_replies[$];
    int                 mismatch_count;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      seconds        = '0;
      age_limit      = mlt_pkg::AGE_LIMIT_RST;
      mismatch_count = 0;
    endfunction

    function int bucket_base(logic [ADDR_W-1:0] a);
      logic [7:0] h;
      h = a[7:0] ^ a[15:8] ^ a[23:16] ^ a[31:24] ^ a[39:32] ^ a[47:40];
      return (int'(h) % NUM_BUCKETS) * WAYS;
    endfunction

    function void set_age_limit(logic [AGE_W-1:0] v);
      age_limit = v;
    endfunction

    function int pending_count();
      return pending_replies.size();
    endfunction

    function void note_command(mlt_pkg::opcode_t op, logic [ADDR_W-1:0] a,
                               logic [PORT_W-1:0] p);
      reply_t             r;
      int                 base;
      int                 slot;
      int                 free_slot;
      int                 n;
      logic [STAMP_W-1:0] age;
      r         = '0;
      base      = bucket_base(a);
      slot      = -1;
      free_slot = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (occupied[base+w] && station[base+w] == a && slot < 0) slot = base + w;
        if (!occupied[base+w] && free_slot < 0) free_slot = base + w;
      end
      case (op)
        mlt_pkg::OP_LEARN: begin
          if (int'(p) < NUM_PORTS) begin
            if (slot >= 0) begin
              last_seen[slot] = seconds;
              r.hit = 1'b1;
            end else if (free_slot < 0) begin
              r.dropped = 1'b1;
            end else begin
              occupied[free_slot]   = 1'b1;
              station[free_slot]    = a;
              bound_port[free_slot] = p;
              last_seen[free_slot]  = seconds;
            end
          end
        end
        mlt_pkg::OP_LOOKUP: begin
          if (slot >= 0) begin
            last_seen[slot] = seconds;
            r.hit  = 1'b1;
            r.port = bound_port[slot];
          end
        end
        mlt_pkg::OP_TICK: begin
          seconds = seconds + 1;
        end
        default: begin
          n = 0;
          for (int i = 0; i < TABLE_SIZE; i++) begin
            age = seconds - last_seen[i];
            if (occupied[i] && age >= STAMP_W'(age_limit)) begin
              occupied[i] = 1'b0;
              if (n < int'(mlt_pkg::COUNT_MAX)) n++;
            end
          end
          r.removed = COUNT_W'(n);
        end
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [23:0] d);
      reply_t got;
      reply_t want;
      got.hit     = d[0];
      got.port    = d[4:1];
      got.dropped = d[5];
      got.removed = d[16:6];
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected reply: hit=%0d port=%0d dropped=%0d removed=%0d",
                   got.hit, got.port, got.dropped, got.removed);
        return;
      end
      want = pending_replies.pop_front();
      if (got.hit !== want.hit || got.port !== want.port ||
          got.dropped !== want.dropped || got.removed !== want.removed) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("reply mismatch: exp hit=%0d port=%0d dropped=%0d removed=%0d, %s",
                   want.hit, want.port, want.dropped, want.removed,
                   $sformatf("got hit=%0d port=%0d dropped=%0d removed=%0d",
                             got.hit, got.port, got.dropped, got.removed));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // mac_addr[47:0], port_in[51:48], zero pad
  logic [1:0]  s_axis_tuser;   // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // hit[0], port_out[4:1], learn_dropped[5], removed_count[16:6]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;       // age_limit[11:0]

  learning_table_shadow shadow = new();
  int replies_seen = 0;
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;

  mac_learning_table_core #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS),
    .NUM_PORTS   (NUM_PORTS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Random address whose byte fold lands in bucket b.
  function automatic logic [ADDR_W-1:0] addr_in_bucket(int b);
    logic [ADDR_W-1:0] a;
    a[31:0]  = $urandom();
    a[47:32] = 16'($urandom_range(0, 65535));
    a[47:40] = a[7:0] ^ a[15:8] ^ a[23:16] ^ a[31:24] ^ a[39:32] ^ 8'(b);
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] any_addr();
    logic [ADDR_W-1:0] a;
    a[31:0]  = $urandom();
    a[47:32] = 16'($urandom_range(0, 65535));
    return a;
  endfunction

  // Observe all three channels on the same edge the block does.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        shadow.note_command(mlt_pkg::opcode_t'(s_axis_tuser), s_axis_tdata[47:0],
                            s_axis_tdata[51:48]);
      if (m_axis_tvalid && m_axis_tready) begin
        shadow.check_reply(m_axis_tdata);
        replies_seen++;
      end
      if (cfg_valid && cfg_ready)
        shadow.set_age_limit(cfg_data);
    end
  end

  // Reply side: random back-pressure plus one long hold so the input backs up.
  initial begin : reply_sink
    int stall;
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (replies_seen % 48 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      if (!held && replies_seen >= 200) begin
        held  = 1'b1;
        stall = 500;
      end else begin
        stall = pick_gap(sink_steady);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  int items_sent = 0;

  task automatic issue_command(mlt_pkg::opcode_t op, logic [ADDR_W-1:0] a,
                               logic [PORT_W-1:0] p);
    int gap;
    if (items_sent % 40 == 0) src_steady = ($urandom_range(0, 3) == 0);
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, p, a};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding reply.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (replies_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_age_limit(logic [AGE_W-1:0] v);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic_phase(int n_items);
    int                hot[8];
    int                n_hot;
    int                r;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] known[$];
    n_hot = $urandom_range(2, 8);
    for (int i = 0; i < 8; i++) hot[i] = $urandom_range(0, NUM_BUCKETS - 1);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (known.size() == 0 && r >= 30 && r < 62) r = 0;
      if (r < 30) begin
        a = addr_in_bucket(hot[$urandom_range(0, n_hot - 1)]);
        known.push_back(a);
        if (known.size() > 48) void'(known.pop_front());
        issue_command(mlt_pkg::OP_LEARN, a, 4'($urandom_range(0, 15)));
      end else if (r < 40) begin
        issue_command(mlt_pkg::OP_LEARN, known[$urandom_range(0, known.size() - 1)],
                      4'($urandom_range(0, 15)));
      end else if (r < 62) begin
        issue_command(mlt_pkg::OP_LOOKUP, known[$urandom_range(0, known.size() - 1)],
                      4'($urandom_range(0, 15)));
      end else if (r < 67) begin
        issue_command(mlt_pkg::OP_LOOKUP, any_addr(), 4'($urandom_range(0, 15)));
      end else if (r < 72) begin
        issue_command(mlt_pkg::OP_LEARN, any_addr(), 4'($urandom_range(0, 15)));
      end else if (r < 92) begin
        issue_command(mlt_pkg::OP_TICK, any_addr(), 4'($urandom_range(0, 15)));
      end else begin
        issue_command(mlt_pkg::OP_SWEEP, any_addr(), 4'($urandom_range(0, 15)));
      end
    end
  endtask

  localparam logic [ADDR_W-1:0] ADDR_ZERO = 48'h0000_0000_0000;
  localparam logic [ADDR_W-1:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
  // all of these fold to bucket 0
  localparam logic [ADDR_W-1:0] ADDR_B0_C = 48'h0101_0000_0000;
  localparam logic [ADDR_W-1:0] ADDR_B0_D = 48'h0000_0000_8080;
  localparam logic [ADDR_W-1:0] ADDR_B0_E = 48'h1234_1234_0000;

  initial begin : stimulus
    int               phase_items[6];
    logic [AGE_W-1:0] phase_limit[6];
    phase_limit = '{12'd3, 12'd1, 12'd0, 12'd4095, 12'd6, 12'd2};
    phase_items = '{130, 120, 100, 130, 140, 130};
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= mlt_pkg::OP_LEARN;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table, then fill bucket 0 past its ways
    issue_command(mlt_pkg::OP_SWEEP,  ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_ONES, 4'd15);
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_ONES, 4'd0);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_ZERO, 4'd5);   // refresh only, port stays
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_ZERO, 4'd15);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_B0_C, 4'd9);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_B0_D, 4'd6);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_B0_E, 4'd3);   // bucket full, dropped
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_B0_E, 4'd0);
    issue_command(mlt_pkg::OP_TICK,   ADDR_ONES, 4'd15);
    issue_command(mlt_pkg::OP_TICK,   ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_SWEEP,  ADDR_ZERO, 4'd0);

    write_age_limit(12'd1);
    issue_command(mlt_pkg::OP_TICK,   ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_B0_C, 4'd0);
    issue_command(mlt_pkg::OP_SWEEP,  ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_B0_E, 4'd10);  // reuses the lowest freed way
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_B0_E, 4'd0);

    // zero limit: everything present counts as aged
    write_age_limit(12'd0);
    issue_command(mlt_pkg::OP_SWEEP,  ADDR_ZERO, 4'd0);
    issue_command(mlt_pkg::OP_LOOKUP, ADDR_B0_C, 4'd0);
    issue_command(mlt_pkg::OP_LEARN,  ADDR_ONES, 4'd15);

    for (int k = 0; k < 6; k++) begin
      write_age_limit(phase_limit[k]);
      run_traffic_phase(phase_items[k]);
    end

    drain_replies();
    repeat (NUM_BUCKETS + 16) @(posedge clk);
    if (shadow.mismatch_count == 0 && shadow.pending_count() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
